>>> rtl/clhg_pkg.sv
// ----------------------------------------------------------------------------
// clhg_pkg
// Shared types, constants and helpers of the Lorenz hop generator.
// ----------------------------------------------------------------------------
package clhg_pkg;

    localparam int STATE_WIDTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int BIN_DIV     = 6;
    localparam int BIN_COUNT   = 4;
    localparam int HALF_WIDTH  = STATE_WIDTH / 2;
    localparam int DIV_BITS    = 4;
    localparam int DIV_ITERS   = STATE_WIDTH / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_ITERS);
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CHAN_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SIGMA      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RHO        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_NUM   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_DEN   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DT_SHIFT   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT = 4'd7;

    localparam logic [4:0] OP_NONE  = 5'd0;
    localparam logic [4:0] OP_LOAD  = 5'd1;
    localparam logic [4:0] OP_XD    = 5'd2;
    localparam logic [4:0] OP_XT    = 5'd3;
    localparam logic [4:0] OP_XU    = 5'd4;
    localparam logic [4:0] OP_YSET  = 5'd5;
    localparam logic [4:0] OP_M0    = 5'd6;
    localparam logic [4:0] OP_M1    = 5'd7;
    localparam logic [4:0] OP_M2    = 5'd8;
    localparam logic [4:0] OP_YD    = 5'd9;
    localparam logic [4:0] OP_YU    = 5'd10;
    localparam logic [4:0] OP_ZSET  = 5'd11;
    localparam logic [4:0] OP_ZQ    = 5'd12;
    localparam logic [4:0] OP_BT    = 5'd13;
    localparam logic [4:0] OP_BDS   = 5'd14;
    localparam logic [4:0] OP_DITER = 5'd15;
    localparam logic [4:0] OP_BF    = 5'd16;
    localparam logic [4:0] OP_ZD    = 5'd17;
    localparam logic [4:0] OP_ZU    = 5'd18;
    localparam logic [4:0] OP_CDS   = 5'd19;
    localparam logic [4:0] OP_CH    = 5'd20;

    typedef logic signed [STATE_WIDTH-1:0] word_t;

    typedef struct packed {
        logic [7:0]  sigma_gain;
        logic [30:0] rho_scaled;
        logic [7:0]  beta_numerator;
        logic [7:0]  beta_denominator;
        logic [4:0]  time_step_shift;
        logic [9:0]  dwell_steps;
        logic [11:0] warmup_steps;
        logic [3:0]  channel_count;
    } cfg_t;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

    // value (0..7) modulo count, count 0 taken as 1
    function automatic logic [CHAN_W-1:0] chan_mod(input logic [CHAN_W-1:0] v,
                                                   input logic [3:0] cnt);
        logic [3:0] c;
        logic [3:0] r;
        c = (cnt == 4'd0) ? 4'd1 : cnt;
        r = {1'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (r >= c) begin
                r = r - c;
            end
        end
        return r[CHAN_W-1:0];
    endfunction

endpackage

>>> rtl/clhg_if.sv
// ----------------------------------------------------------------------------
// clhg_in_if / clhg_out_if / clhg_cfg_if
// Valid/ready channels of the hop generator.
// ----------------------------------------------------------------------------
interface clhg_in_if;
    logic                valid;
    logic                ready;
    logic                action;
    logic signed [63:0]  load_x;
    logic signed [63:0]  load_y;
    logic signed [63:0]  load_z;
    modport source (output valid, action, load_x, load_y, load_z, input ready);
    modport sink   (input valid, action, load_x, load_y, load_z, output ready);
endinterface

interface clhg_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] channel;
    modport source (output valid, channel, input ready);
    modport sink   (input valid, channel, output ready);
endinterface

interface clhg_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/clhg_datapath.sv
// ----------------------------------------------------------------------------
// clhg_datapath
// State registers, shared 32x32 multiplier and radix-16 divider.
// ----------------------------------------------------------------------------
module clhg_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  clhg_pkg::cmd_t      cmd,
    output clhg_pkg::status_t   status,
    input  clhg_pkg::cfg_t      cfg,
    input  clhg_pkg::word_t     load_x,
    input  clhg_pkg::word_t     load_y,
    input  clhg_pkg::word_t     load_z,
    output logic [2:0]          channel
);
    localparam int W = clhg_pkg::STATE_WIDTH;
    localparam int H = clhg_pkg::HALF_WIDTH;

    clhg_pkg::word_t x_reg, y_reg, z_reg;
    clhg_pkg::word_t d_reg, t_reg, q_reg, acc_reg;
    logic [W-1:0]    ma_reg, mb_reg, dq_reg;
    logic [7:0]      rem_reg, dv_reg;
    logic            dneg_reg;
    logic [clhg_pkg::DIV_CNT_W-1:0] dcnt_reg;
    logic [2:0]      chan_reg;

    logic [H-1:0]    mop_a, mop_b;
    logic [W-1:0]    prod;
    logic [W-1:0]    dq_step;
    logic [7:0]      rem_step;
    logic [8:0]      r9;
    logic [W-1:0]    zmag;
    logic [7:0]      rem_v;
    logic [W-1:0]    dq_v;
    logic [W-1:0]    tmag;
    logic [2:0]      chan_v;

    assign mop_a = (cmd.op == clhg_pkg::OP_M1) ? ma_reg[W-1:H] : ma_reg[H-1:0];
    assign mop_b = (cmd.op == clhg_pkg::OP_M2) ? mb_reg[W-1:H] : mb_reg[H-1:0];
    assign prod  = mop_a * mop_b;
    assign zmag  = z_reg[W-1] ? (~z_reg + 1'b1) : z_reg;
    assign tmag  = t_reg[W-1] ? (~t_reg + 1'b1) : t_reg;
    assign chan_v = {(y_reg[W-1] || (y_reg == '0)), dq_reg[1:0]};

    always_comb
    begin
        rem_v = rem_reg;
        dq_v  = dq_reg;
        r9    = '0;
        for (int i = 0; i < clhg_pkg::DIV_BITS; i++) begin
            r9   = {rem_v, dq_v[W-1]};
            dq_v = {dq_v[W-2:0], 1'b0};
            if (r9 >= {1'b0, dv_reg}) begin
                r9      = r9 - {1'b0, dv_reg};
                dq_v[0] = 1'b1;
            end
            rem_v = r9[7:0];
        end
        rem_step = rem_v;
        dq_step  = dq_v;
    end

    assign status.div_done = (dcnt_reg == clhg_pkg::DIV_CNT_W'(clhg_pkg::DIV_ITERS - 1));
    assign channel = chan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            dcnt_reg <= '0;
        end else begin
            case (cmd.op)
                clhg_pkg::OP_LOAD:
                begin
                    x_reg <= load_x;
                    y_reg <= load_y;
                    z_reg <= load_z;
                end
                clhg_pkg::OP_XD: d_reg <= y_reg - x_reg;
                clhg_pkg::OP_XT: t_reg <= W'(d_reg * $signed({1'b0, cfg.sigma_gain}));
                clhg_pkg::OP_XU: x_reg <= x_reg + (t_reg >>> cfg.time_step_shift);
                clhg_pkg::OP_YSET:
                begin
                    ma_reg <= x_reg;
                    mb_reg <= {{(W-31){1'b0}}, cfg.rho_scaled} - z_reg;
                end
                clhg_pkg::OP_M0: acc_reg <= prod;
                clhg_pkg::OP_M1,
                clhg_pkg::OP_M2: acc_reg <= acc_reg + {prod[H-1:0], {H{1'b0}}};
                clhg_pkg::OP_YD: d_reg <= (acc_reg >>> clhg_pkg::FRAC_BITS) - y_reg;
                clhg_pkg::OP_YU: y_reg <= y_reg + (d_reg >>> cfg.time_step_shift);
                clhg_pkg::OP_ZSET:
                begin
                    ma_reg <= x_reg;
                    mb_reg <= y_reg;
                end
                clhg_pkg::OP_ZQ: q_reg <= acc_reg >>> clhg_pkg::FRAC_BITS;
                clhg_pkg::OP_BT: t_reg <= W'(z_reg * $signed({1'b0, cfg.beta_numerator}));
                clhg_pkg::OP_BDS:
                begin
                    dq_reg   <= tmag;
                    rem_reg  <= '0;
                    dneg_reg <= t_reg[W-1];
                    dv_reg   <= (cfg.beta_denominator == 8'd0) ? 8'd1 : cfg.beta_denominator;
                    dcnt_reg <= '0;
                end
                clhg_pkg::OP_DITER:
                begin
                    dq_reg   <= dq_step;
                    rem_reg  <= rem_step;
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                clhg_pkg::OP_BF:
                begin
                    if (dneg_reg) begin
                        t_reg <= ~(dq_reg + W'(rem_reg != 8'd0)) + 1'b1;
                    end else begin
                        t_reg <= dq_reg;
                    end
                end
                clhg_pkg::OP_ZD: d_reg <= q_reg - t_reg;
                clhg_pkg::OP_ZU: z_reg <= z_reg + (d_reg >>> cfg.time_step_shift);
                clhg_pkg::OP_CDS:
                begin
                    dq_reg   <= zmag >> clhg_pkg::FRAC_BITS;
                    rem_reg  <= '0;
                    dneg_reg <= 1'b0;
                    dv_reg   <= 8'(clhg_pkg::BIN_DIV);
                    dcnt_reg <= '0;
                end
                clhg_pkg::OP_CH: chan_reg <= clhg_pkg::chan_mod(chan_v, cfg.channel_count);
                default:
                begin
                end
            endcase
        end
    end
endmodule

>>> rtl/clhg_ctrl.sv
// ----------------------------------------------------------------------------
// clhg_ctrl
// Step sequencer: steps count, micro-op order, input and output handshake.
// ----------------------------------------------------------------------------
module clhg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_action,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  clhg_pkg::cfg_t      cfg,
    input  clhg_pkg::status_t   status,
    output clhg_pkg::cmd_t      cmd
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CHK  = 5'd1;
    localparam logic [4:0] S_XD   = 5'd2;
    localparam logic [4:0] S_XT   = 5'd3;
    localparam logic [4:0] S_XU   = 5'd4;
    localparam logic [4:0] S_YSET = 5'd5;
    localparam logic [4:0] S_YM0  = 5'd6;
    localparam logic [4:0] S_YM1  = 5'd7;
    localparam logic [4:0] S_YM2  = 5'd8;
    localparam logic [4:0] S_YD   = 5'd9;
    localparam logic [4:0] S_YU   = 5'd10;
    localparam logic [4:0] S_ZSET = 5'd11;
    localparam logic [4:0] S_ZM0  = 5'd12;
    localparam logic [4:0] S_ZM1  = 5'd13;
    localparam logic [4:0] S_ZM2  = 5'd14;
    localparam logic [4:0] S_ZQ   = 5'd15;
    localparam logic [4:0] S_BT   = 5'd16;
    localparam logic [4:0] S_BDS  = 5'd17;
    localparam logic [4:0] S_BDI  = 5'd18;
    localparam logic [4:0] S_BF   = 5'd19;
    localparam logic [4:0] S_ZD   = 5'd20;
    localparam logic [4:0] S_ZU   = 5'd21;
    localparam logic [4:0] S_CDS  = 5'd22;
    localparam logic [4:0] S_CDI  = 5'd23;
    localparam logic [4:0] S_FIN  = 5'd24;

    logic [4:0]  state_reg, state_next;
    logic [11:0] steps_reg, steps_next;
    logic        hop_reg, hop_next;
    logic        ovalid_reg, ovalid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        steps_next  = steps_reg;
        hop_next    = hop_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd.op      = clhg_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    hop_next   = in_action;
                    state_next = S_CHK;
                    if (in_action) begin
                        steps_next = {2'b00, cfg.dwell_steps};
                    end else begin
                        steps_next = cfg.warmup_steps;
                        cmd.op     = clhg_pkg::OP_LOAD;
                    end
                end
            end
            S_CHK:
            begin
                if (steps_reg != 12'd0) begin
                    steps_next = steps_reg - 1'b1;
                    state_next = S_XD;
                end else begin
                    state_next = hop_reg ? S_CDS : S_IDLE;
                end
            end
            S_XD:   begin cmd.op = clhg_pkg::OP_XD;   state_next = S_XT;   end
            S_XT:   begin cmd.op = clhg_pkg::OP_XT;   state_next = S_XU;   end
            S_XU:   begin cmd.op = clhg_pkg::OP_XU;   state_next = S_YSET; end
            S_YSET: begin cmd.op = clhg_pkg::OP_YSET; state_next = S_YM0;  end
            S_YM0:  begin cmd.op = clhg_pkg::OP_M0;   state_next = S_YM1;  end
            S_YM1:  begin cmd.op = clhg_pkg::OP_M1;   state_next = S_YM2;  end
            S_YM2:  begin cmd.op = clhg_pkg::OP_M2;   state_next = S_YD;   end
            S_YD:   begin cmd.op = clhg_pkg::OP_YD;   state_next = S_YU;   end
            S_YU:   begin cmd.op = clhg_pkg::OP_YU;   state_next = S_ZSET; end
            S_ZSET: begin cmd.op = clhg_pkg::OP_ZSET; state_next = S_ZM0;  end
            S_ZM0:  begin cmd.op = clhg_pkg::OP_M0;   state_next = S_ZM1;  end
            S_ZM1:  begin cmd.op = clhg_pkg::OP_M1;   state_next = S_ZM2;  end
            S_ZM2:  begin cmd.op = clhg_pkg::OP_M2;   state_next = S_ZQ;   end
            S_ZQ:   begin cmd.op = clhg_pkg::OP_ZQ;   state_next = S_BT;   end
            S_BT:   begin cmd.op = clhg_pkg::OP_BT;   state_next = S_BDS;  end
            S_BDS:  begin cmd.op = clhg_pkg::OP_BDS;  state_next = S_BDI;  end
            S_BDI:
            begin
                cmd.op = clhg_pkg::OP_DITER;
                if (status.div_done) begin
                    state_next = S_BF;
                end
            end
            S_BF:   begin cmd.op = clhg_pkg::OP_BF;   state_next = S_ZD;   end
            S_ZD:   begin cmd.op = clhg_pkg::OP_ZD;   state_next = S_ZU;   end
            S_ZU:   begin cmd.op = clhg_pkg::OP_ZU;   state_next = S_CHK;  end
            S_CDS:  begin cmd.op = clhg_pkg::OP_CDS;  state_next = S_CDI;  end
            S_CDI:
            begin
                cmd.op = clhg_pkg::OP_DITER;
                if (status.div_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || out_ready) begin
                    cmd.op      = clhg_pkg::OP_CH;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            steps_reg  <= '0;
            hop_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            steps_reg  <= steps_next;
            hop_reg    <= hop_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

>>> rtl/chaotic_lorenz_hop_generator.sv
// ----------------------------------------------------------------------------
// chaotic_lorenz_hop_generator
// Fixed-point Lorenz attractor driving a hop channel sequence.
// ----------------------------------------------------------------------------
// One item at a time. Each Euler step computes the two 64-bit products
// of the y and z updates, each built from three passes of one 32x32
// multiplier, and runs a radix-16 divider for the beta term. A load runs
// warmup steps; a hop runs dwell steps and then a divider pass that bins |z|.
// The result waits in an output register; the next item is taken once the
// sequencer is back in idle.
module chaotic_lorenz_hop_generator (
    input  logic       clk,
    input  logic       rst_n,
    clhg_cfg_if.sink   cfg,
    clhg_in_if.sink    hop_in,
    clhg_out_if.source hop_out
);
    clhg_pkg::cfg_t    cfg_reg;
    clhg_pkg::cmd_t    cmd;
    clhg_pkg::status_t status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.sigma_gain       <= 8'd10;
            cfg_reg.rho_scaled       <= 31'd1835008;
            cfg_reg.beta_numerator   <= 8'd8;
            cfg_reg.beta_denominator <= 8'd3;
            cfg_reg.time_step_shift  <= 5'd8;
            cfg_reg.dwell_steps      <= 10'd16;
            cfg_reg.warmup_steps     <= 12'd256;
            cfg_reg.channel_count    <= 4'd8;
        end else if (cfg.valid) begin
            case (cfg.index)
                clhg_pkg::REG_SIGMA:      cfg_reg.sigma_gain       <= cfg.data[7:0];
                clhg_pkg::REG_RHO:        cfg_reg.rho_scaled       <= cfg.data[30:0];
                clhg_pkg::REG_BETA_NUM:   cfg_reg.beta_numerator   <= cfg.data[7:0];
                clhg_pkg::REG_BETA_DEN:   cfg_reg.beta_denominator <= cfg.data[7:0];
                clhg_pkg::REG_DT_SHIFT:   cfg_reg.time_step_shift  <= cfg.data[4:0];
                clhg_pkg::REG_DWELL:      cfg_reg.dwell_steps      <= cfg.data[9:0];
                clhg_pkg::REG_WARMUP:     cfg_reg.warmup_steps     <= cfg.data[11:0];
                clhg_pkg::REG_CHAN_COUNT: cfg_reg.channel_count    <= cfg.data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    clhg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hop_in.valid),
        .in_action (hop_in.action),
        .in_ready  (hop_in.ready),
        .out_valid (hop_out.valid),
        .out_ready (hop_out.ready),
        .cfg       (cfg_reg),
        .status    (status),
        .cmd       (cmd)
    );

    clhg_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .cfg     (cfg_reg),
        .load_x  (hop_in.load_x),
        .load_y  (hop_in.load_y),
        .load_z  (hop_in.load_z),
        .channel (hop_out.channel)
    );

    a_accept_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
        (hop_in.valid && hop_in.ready) |=> !$rose(hop_out.valid))
        else $error("result appeared right after accept");

    a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (hop_in.valid && hop_in.ready) |=> !hop_in.ready)
        else $error("ready stayed high after accept");

    a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hop_out.valid && cfg_reg.channel_count != 4'd0)
        |-> ({1'b0, hop_out.channel} < cfg_reg.channel_count))
        else $error("channel beyond channel count");
endmodule
